### design/mcbp_pkg.sv
// Shared types and constants of the MQTT CONNECT body parser.
// Used by the request queue, the parsing engine and the top level; no dependencies.
package mcbp_pkg;

   localparam int QueueDepth = 2;

   localparam logic [3:0] KindLenPrefix  = 4'd0;
   localparam logic [3:0] KindProtoName  = 4'd1;
   localparam logic [3:0] KindVersion    = 4'd2;
   localparam logic [3:0] KindFlags      = 4'd3;
   localparam logic [3:0] KindKeepAlive  = 4'd4;
   localparam logic [3:0] KindClientId   = 4'd5;
   localparam logic [3:0] KindWillTopic  = 4'd6;
   localparam logic [3:0] KindWillPaylod = 4'd7;
   localparam logic [3:0] KindUsername   = 4'd8;
   localparam logic [3:0] KindPassword   = 4'd9;
   localparam logic [3:0] KindTrailing   = 4'd10;
   localparam logic [3:0] KindAfterError = 4'd11;

   localparam logic [1:0] StatusBusy      = 2'd0;
   localparam logic [1:0] StatusComplete  = 2'd1;
   localparam logic [1:0] StatusTruncated = 2'd2;

   // One body byte as it waits in the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } item_type;

   // One parse result.
   typedef struct packed {
      logic [3:0]  field_kind;
      logic [7:0]  byte_value;
      logic [15:0] string_length;
      logic [7:0]  flags;
      logic [15:0] ka_seconds;
      logic [1:0]  status;
   } result_type;

endpackage

### design/mcbp_queue.sv
// Short request queue between the accepting front and the parsing engine.
// Depends on mcbp_pkg for the item type and the queue depth.
module mcbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mcbp_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mcbp_pkg::item_type pop_item
);

   localparam int PtrWidth   = (mcbp_pkg::QueueDepth > 1) ? $clog2(mcbp_pkg::QueueDepth) : 1;
   localparam int CountWidth = $clog2(mcbp_pkg::QueueDepth + 1);
   localparam logic [PtrWidth-1:0]   LastSlot = PtrWidth'(mcbp_pkg::QueueDepth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(mcbp_pkg::QueueDepth);

   mcbp_pkg::item_type slots_ff [mcbp_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic push_fire;
   logic pop_fire;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : PtrWidth'(wr_ptr_ff + 1'b1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : PtrWidth'(rd_ptr_ff + 1'b1);
      end
      if (push_fire && !pop_fire) begin
         count_in = CountWidth'(count_ff + 1'b1);
      end else if (pop_fire && !push_fire) begin
         count_in = CountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/mcbp_engine.sv
// Parsing engine: holds the result register and walks the CONNECT fields one byte per cycle while it is not stalled.
// Depends on mcbp_pkg for the item and result types and the field and status codes.
module mcbp_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mcbp_pkg::item_type   in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mcbp_pkg::result_type out_result
);

   typedef enum logic [3:0] {
      PH_PN_LEN  = 4'd0,
      PH_PN      = 4'd1,
      PH_VER     = 4'd2,
      PH_FLAGS   = 4'd3,
      PH_KA      = 4'd4,
      PH_CID_LEN = 4'd5,
      PH_CID     = 4'd6,
      PH_WT_LEN  = 4'd7,
      PH_WT      = 4'd8,
      PH_WP_LEN  = 4'd9,
      PH_WP      = 4'd10,
      PH_UN_LEN  = 4'd11,
      PH_UN      = 4'd12,
      PH_PW_LEN  = 4'd13,
      PH_PW      = 4'd14,
      PH_DONE    = 4'd15
   } phase_type;

   // First optional section that the flags ask for, from stage 0 (will),
   // 1 (username) or 2 (password) on.
   function automatic phase_type optional_from(input logic [1:0] stage, input logic [7:0] fl);
      phase_type res;
      if (stage == 2'd0 && fl[2]) begin
         res = PH_WT_LEN;
      end else if (stage <= 2'd1 && fl[7]) begin
         res = PH_UN_LEN;
      end else if (stage <= 2'd2 && fl[6]) begin
         res = PH_PW_LEN;
      end else begin
         res = PH_DONE;
      end
      return res;
   endfunction

   function automatic phase_type after_string(input phase_type sp, input logic [7:0] fl);
      phase_type res;
      case (sp)
         PH_PN:   res = PH_VER;
         PH_CID:  res = optional_from(2'd0, fl);
         PH_WT:   res = PH_WP_LEN;
         PH_WP:   res = optional_from(2'd1, fl);
         PH_UN:   res = optional_from(2'd2, fl);
         default: res = PH_DONE;
      endcase
      return res;
   endfunction

   function automatic logic [3:0] kind_of(input phase_type ph);
      logic [3:0] res;
      case (ph)
         PH_PN:    res = mcbp_pkg::KindProtoName;
         PH_VER:   res = mcbp_pkg::KindVersion;
         PH_FLAGS: res = mcbp_pkg::KindFlags;
         PH_KA:    res = mcbp_pkg::KindKeepAlive;
         PH_CID:   res = mcbp_pkg::KindClientId;
         PH_WT:    res = mcbp_pkg::KindWillTopic;
         PH_WP:    res = mcbp_pkg::KindWillPaylod;
         PH_UN:    res = mcbp_pkg::KindUsername;
         PH_PW:    res = mcbp_pkg::KindPassword;
         PH_DONE:  res = mcbp_pkg::KindTrailing;
         default:  res = mcbp_pkg::KindLenPrefix;
      endcase
      return res;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] cur_length_ff, cur_length_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] keepalive_ff, keepalive_in;
   logic        error_ff, error_in;
   logic        out_valid_ff, out_valid_in;
   mcbp_pkg::result_type out_result_ff, out_result_in;

   // State as seen by this byte, after the restart that first_byte asks for.
   phase_type   ph;
   logic [15:0] bc;
   logic [15:0] cl;
   logic [7:0]  fl;
   logic [15:0] ka;
   logic        er;
   logic [15:0] bc_inc;
   logic [15:0] prefix_len;
   logic        fire;

   assign in_ready   = !out_valid_ff || out_ready;
   assign fire       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

   always_comb begin
      ph = in_item.first_byte ? PH_PN_LEN : phase_ff;
      bc = in_item.first_byte ? 16'd0 : byte_count_ff;
      cl = in_item.first_byte ? 16'd0 : cur_length_ff;
      fl = in_item.first_byte ? 8'd0  : flags_ff;
      ka = in_item.first_byte ? 16'd0 : keepalive_ff;
      er = in_item.first_byte ? 1'b0  : error_ff;
      bc_inc     = 16'(bc + 16'd1);
      prefix_len = {cl[15:8], in_item.data_byte};

      phase_in      = ph;
      byte_count_in = bc;
      cur_length_in = cl;
      flags_in      = fl;
      keepalive_in  = ka;
      error_in      = er;

      out_result_in.field_kind    = kind_of(ph);
      out_result_in.byte_value    = in_item.data_byte;
      out_result_in.string_length = cl;
      out_result_in.status        = mcbp_pkg::StatusBusy;

      if (er) begin
         out_result_in.field_kind = mcbp_pkg::KindAfterError;
         out_result_in.status     = mcbp_pkg::StatusTruncated;
      end else if (ph == PH_DONE) begin
         out_result_in.status = mcbp_pkg::StatusComplete;
      end else begin
         case (ph)
            PH_PN_LEN, PH_CID_LEN, PH_WT_LEN, PH_WP_LEN, PH_UN_LEN, PH_PW_LEN: begin
               if (bc == 16'd0) begin
                  cur_length_in = {in_item.data_byte, 8'd0};
                  byte_count_in = 16'd1;
                  out_result_in.string_length = 16'd0;
               end else begin
                  cur_length_in = prefix_len;
                  byte_count_in = 16'd0;
                  out_result_in.string_length = prefix_len;
                  // An empty string skips its body phase altogether.
                  phase_in = (prefix_len != 16'd0) ? phase_type'(4'(ph + 4'd1))
                                                   : after_string(phase_type'(4'(ph + 4'd1)), fl);
               end
            end
            PH_VER: begin
               phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               flags_in = in_item.data_byte;
               phase_in = PH_KA;
            end
            PH_KA: begin
               if (bc == 16'd0) begin
                  keepalive_in  = {in_item.data_byte, 8'd0};
                  byte_count_in = 16'd1;
               end else begin
                  keepalive_in  = {ka[15:8], in_item.data_byte};
                  byte_count_in = 16'd0;
                  phase_in      = PH_CID_LEN;
               end
            end
            default: begin
               byte_count_in = bc_inc;
               if (bc_inc >= cl) begin
                  byte_count_in = 16'd0;
                  phase_in      = after_string(ph, fl);
               end
            end
         endcase
         out_result_in.status = (phase_in == PH_DONE) ? mcbp_pkg::StatusComplete
                                                      : mcbp_pkg::StatusBusy;
         if (in_item.last_byte && phase_in != PH_DONE) begin
            error_in             = 1'b1;
            out_result_in.status = mcbp_pkg::StatusTruncated;
         end
      end

      out_result_in.flags      = flags_in;
      out_result_in.ka_seconds = keepalive_in;

      out_valid_in = fire ? 1'b1 : (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PN_LEN;
         byte_count_ff <= '0;
         cur_length_ff <= '0;
         flags_ff      <= '0;
         keepalive_ff  <= '0;
         error_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_result_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            phase_ff      <= phase_in;
            byte_count_ff <= byte_count_in;
            cur_length_ff <= cur_length_in;
            flags_ff      <= flags_in;
            keepalive_ff  <= keepalive_in;
            error_ff      <= error_in;
            out_result_ff <= out_result_in;
         end
      end
   end

endmodule

### design/mqtt_connect_body_parser.sv
// Top level of the MQTT 3.1.1 CONNECT body parser: stream ports, request queue, engine.
// Depends on mcbp_pkg, mcbp_queue and mcbp_engine.
// A request is registered in the queue, then in the engine's result register, before its answer.
// Throughput: one request per cycle sustained while the receiver takes responses.
// Reset (synchronous, active high) empties the queue, drops any held response and returns
// the parser to the protocol name length prefix with flags, keep-alive and lengths at zero.
module mqtt_connect_body_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] byte_value, [23:8] string_length, [24] user_flag,
                                    // [25] pass_flag, [26] lwt_retain, [28:27] lwt_qos,
                                    // [29] will_present, [30] fresh_session, [31] reserved_bit,
                                    // [47:32] ka_seconds, [49:48] status, [55:50] zero
   output logic [3:0]  rsp_tuser    // [3:0] field_kind
);

   // The front side only takes requests into the queue; the engine drains it whenever
   // its result register is free or being emptied, so a stalled response never blocks
   // the input for the depth of the queue.
   mcbp_pkg::item_type   req_item;
   mcbp_pkg::item_type   eng_item;
   mcbp_pkg::result_type eng_result;
   logic                 eng_valid;
   logic                 eng_ready;

   assign req_item.data_byte  = req_tdata;
   assign req_item.first_byte = req_tuser[0];
   assign req_item.last_byte  = req_tlast;

   mcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (req_item),
      .pop_valid  (eng_valid),
      .pop_ready  (eng_ready),
      .pop_item   (eng_item)
   );

   mcbp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (eng_valid),
      .in_ready   (eng_ready),
      .in_item    (eng_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (eng_result)
   );

   // The flags byte maps bit for bit onto user_flag..reserved_bit, so its fields are
   // placed in reversed order, lwt_qos keeping its bit order; connect flags bit 7 lands lowest.
   assign rsp_tuser = eng_result.field_kind;
   assign rsp_tdata = {6'd0,
                       eng_result.status,
                       eng_result.ka_seconds,
                       eng_result.flags[0],
                       eng_result.flags[1],
                       eng_result.flags[2],
                       eng_result.flags[4:3],
                       eng_result.flags[5],
                       eng_result.flags[6],
                       eng_result.flags[7],
                       eng_result.string_length,
                       eng_result.byte_value};

endmodule

### design/mcbp_checker.sv
// Port-level checks for the CONNECT body parser, bound to the top level.
// Depends on mqtt_connect_body_parser's port list and on mcbp_pkg for the codes.
module mcbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Bytes after a truncation always report the truncated status.
   a_error_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mcbp_pkg::KindAfterError
      |-> rsp_tdata[49:48] == mcbp_pkg::StatusTruncated)
      else $error("after-error byte without truncated status");

   // Trailing bytes only follow a complete packet.
   a_trailing_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mcbp_pkg::KindTrailing
      |-> rsp_tdata[49:48] == mcbp_pkg::StatusComplete)
      else $error("trailing byte without complete status");

   // Nothing is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind mqtt_connect_body_parser mcbp_checker u_mcbp_checker (.*);

### verif/mcbp_result_checker.sv
// Response checker for the MQTT CONNECT body parser: watches both stream channels,
// predicts each response from the accepted requests and compares it field by field.
// Depends on mcbp_pkg for the field kind and status codes and the result type.
`timescale 1ns / 1ps

module mcbp_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // [7:0] byte_value, [23:8] string_length, [24] user_flag,
                                    // [25] pass_flag, [26] lwt_retain, [28:27] lwt_qos,
                                    // [29] will_present, [30] fresh_session, [31] reserved_bit,
                                    // [47:32] ka_seconds, [49:48] status, [55:50] zero
   input  logic [3:0]  rsp_tuser,   // [3:0] field_kind
   output int          mismatch_count,
   output int          pending_count,
   output int          bodies_complete,
   output int          bodies_truncated,
   output int          trailing_bytes
);

   typedef enum logic [3:0] {
      PhProtoLen, PhProtoName, PhVersion, PhFlags, PhKeepAlive, PhClientLen, PhClientId,
      PhWillTopicLen, PhWillTopic, PhWillPayLen, PhWillPayload, PhUserLen, PhUser,
      PhPassLen, PhPass, PhDone
   } parse_phase_type;

   parse_phase_type ph;
   logic [15:0]     pos_count;
   logic [15:0]     decl_len;
   logic [7:0]      flags_seen;
   logic [15:0]     keepalive_seen;
   logic            truncated;

   mcbp_pkg::result_type expected_q[$];
   mcbp_pkg::result_type predicted;
   mcbp_pkg::result_type want;

   function automatic void clear_parser();
      ph             = PhProtoLen;
      pos_count      = '0;
      decl_len       = '0;
      flags_seen     = '0;
      keepalive_seen = '0;
      truncated      = 1'b0;
   endfunction

   // Where the walk goes once the client id or an optional string is done,
   // starting the search at the will (0), the username (1) or the password (2).
   function automatic parse_phase_type optional_after(input int stage);
      if (stage == 0 && flags_seen[2]) return PhWillTopicLen;
      if (stage <= 1 && flags_seen[7]) return PhUserLen;
      if (stage <= 2 && flags_seen[6]) return PhPassLen;
      return PhDone;
   endfunction

   function automatic parse_phase_type phase_after_string(input parse_phase_type sp);
      case (sp)
         PhProtoName:   return PhVersion;
         PhClientId:    return optional_after(0);
         PhWillTopic:   return PhWillPayLen;
         PhWillPayload: return optional_after(1);
         PhUser:        return optional_after(2);
         default:       return PhDone;
      endcase
   endfunction

   function automatic logic [3:0] kind_of_phase(input parse_phase_type p);
      case (p)
         PhProtoName:   return mcbp_pkg::KindProtoName;
         PhVersion:     return mcbp_pkg::KindVersion;
         PhFlags:       return mcbp_pkg::KindFlags;
         PhKeepAlive:   return mcbp_pkg::KindKeepAlive;
         PhClientId:    return mcbp_pkg::KindClientId;
         PhWillTopic:   return mcbp_pkg::KindWillTopic;
         PhWillPayload: return mcbp_pkg::KindWillPaylod;
         PhUser:        return mcbp_pkg::KindUsername;
         PhPass:        return mcbp_pkg::KindPassword;
         PhDone:        return mcbp_pkg::KindTrailing;
         default:       return mcbp_pkg::KindLenPrefix;
      endcase
   endfunction

   // Advances the parser by one body byte and returns the response it should give.
   function automatic mcbp_pkg::result_type parse_byte(input logic [7:0] b, input logic first,
                                                       input logic last);
      mcbp_pkg::result_type r;
      if (first) clear_parser();
      r.byte_value    = b;
      r.string_length = decl_len;
      if (truncated) begin
         r.field_kind = mcbp_pkg::KindAfterError;
         r.status     = mcbp_pkg::StatusTruncated;
      end else if (ph == PhDone) begin
         r.field_kind = mcbp_pkg::KindTrailing;
         r.status     = mcbp_pkg::StatusComplete;
      end else begin
         r.field_kind = kind_of_phase(ph);
         case (ph)
            PhProtoLen, PhClientLen, PhWillTopicLen, PhWillPayLen, PhUserLen, PhPassLen: begin
               if (pos_count == 16'd0) begin
                  decl_len        = {b, 8'h00};
                  pos_count       = 16'd1;
                  r.string_length = '0;
               end else begin
                  decl_len        = decl_len | {8'h00, b};
                  pos_count       = '0;
                  r.string_length = decl_len;
                  // An empty string is skipped right away.
                  ph = (decl_len != 16'd0)
                       ? parse_phase_type'(4'(ph + 4'd1))
                       : phase_after_string(parse_phase_type'(4'(ph + 4'd1)));
               end
            end
            PhVersion: ph = PhFlags;
            PhFlags: begin
               flags_seen = b;
               ph         = PhKeepAlive;
            end
            PhKeepAlive: begin
               if (pos_count == 16'd0) begin
                  keepalive_seen = {b, 8'h00};
                  pos_count      = 16'd1;
               end else begin
                  keepalive_seen = keepalive_seen | {8'h00, b};
                  pos_count      = '0;
                  ph             = PhClientLen;
               end
            end
            default: begin
               pos_count = 16'(pos_count + 16'd1);
               if (pos_count >= decl_len) begin
                  pos_count = '0;
                  ph        = phase_after_string(ph);
               end
            end
         endcase
         r.status = (ph == PhDone) ? mcbp_pkg::StatusComplete : mcbp_pkg::StatusBusy;
         if (last && ph != PhDone) begin
            truncated = 1'b1;
            r.status  = mcbp_pkg::StatusTruncated;
         end
      end
      r.flags      = flags_seen;
      r.ka_seconds = keepalive_seen;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_q.delete();
         mismatch_count   = 0;
         bodies_complete  = 0;
         bodies_truncated = 0;
         trailing_bytes   = 0;
      end else begin
         // A response always belongs to an earlier request, so it is checked first.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("response with no request pending, byte_value %0h",
                                         rsp_tdata[7:0]));
            end else begin
               want = expected_q.pop_front();
               check_field("field_kind", 16'(rsp_tuser), 16'(want.field_kind));
               check_field("byte_value", 16'(rsp_tdata[7:0]), 16'(want.byte_value));
               check_field("string_length", rsp_tdata[23:8], want.string_length);
               check_field("user_flag", 16'(rsp_tdata[24]), 16'(want.flags[7]));
               check_field("pass_flag", 16'(rsp_tdata[25]), 16'(want.flags[6]));
               check_field("lwt_retain", 16'(rsp_tdata[26]), 16'(want.flags[5]));
               check_field("lwt_qos", 16'(rsp_tdata[28:27]), 16'(want.flags[4:3]));
               check_field("will_present", 16'(rsp_tdata[29]), 16'(want.flags[2]));
               check_field("fresh_session", 16'(rsp_tdata[30]), 16'(want.flags[1]));
               check_field("reserved_bit", 16'(rsp_tdata[31]), 16'(want.flags[0]));
               check_field("ka_seconds", rsp_tdata[47:32], want.ka_seconds);
               check_field("status", 16'(rsp_tdata[49:48]), 16'(want.status));
               check_field("padding", 16'(rsp_tdata[55:50]), 16'h0000);
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = parse_byte(req_tdata, req_tuser[0], req_tlast);
            if (predicted.field_kind == mcbp_pkg::KindTrailing) trailing_bytes++;
            else if (predicted.status == mcbp_pkg::StatusComplete) bodies_complete++;
            else if (predicted.status == mcbp_pkg::StatusTruncated &&
                     predicted.field_kind != mcbp_pkg::KindAfterError) bodies_truncated++;
            expected_q.push_back(predicted);
         end
      end
      pending_count = expected_q.size();
   end

endmodule

### verif/tb.sv
// Top of the MQTT CONNECT body parser testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on mcbp_pkg, the parser
// top level and mcbp_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;

   // The watchdog must outlast the longest receiver hold-off by a wide margin.
   localparam int StallLimit    = 2000;
   localparam int HoldOffCycles = 300;
   localparam int TargetItems   = 830;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tlast  = 1'b0; // last_byte
   logic [0:0]  req_tuser  = '0;   // [0] first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // byte_value, string_length, flags, ka_seconds, status
   logic [3:0]  rsp_tuser;         // [3:0] field_kind

   int mismatch_count;
   int pending_count;
   int bodies_complete;
   int bodies_truncated;
   int trailing_bytes;

   // Every request of the run is prepared up front; body_bytes is the scratch
   // area in which one CONNECT body is assembled before it is cut and queued.
   mcbp_pkg::item_type stim_q[$];
   logic [7:0]         body_bytes[$];

   int next_idx       = 0;
   int accepted_count = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   int          rx_cycle   = 0;
   int          hold_left  = 0;
   logic [15:0] ready_mask = '1;

   mqtt_connect_body_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mcbp_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .bodies_complete  (bodies_complete),
      .bodies_truncated (bodies_truncated),
      .trailing_bytes   (trailing_bytes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic push_item(input logic [7:0] data, input logic first, input logic last);
      mcbp_pkg::item_type it;
      it.data_byte  = data;
      it.first_byte = first;
      it.last_byte  = last;
      stim_q.push_back(it);
   endtask

   // Length prefix followed by the string; the content stops once the body
   // reaches cap bytes, which is how huge declared lengths stay cheap.
   task automatic add_string(input int len, input int cap);
      int i;
      body_bytes.push_back(8'(len >> 8));
      body_bytes.push_back(8'(len));
      for (i = 0; i < len && body_bytes.size() < cap; i++)
         body_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Assembles a body, well-formed unless cap cuts it; the flags byte selects the optional strings.
   task automatic build_body(input logic [7:0] flags, input logic [15:0] ka,
                             input int pn_len, input int cid_len, input int wt_len,
                             input int wp_len, input int un_len, input int pw_len,
                             input int cap);
      body_bytes.delete();
      add_string(pn_len, cap);
      body_bytes.push_back($urandom_range(0, 1) ? 8'h04 : 8'($urandom_range(0, 255)));
      body_bytes.push_back(flags);
      body_bytes.push_back(ka[15:8]);
      body_bytes.push_back(ka[7:0]);
      add_string(cid_len, cap);
      if (flags[2]) begin
         add_string(wt_len, cap);
         add_string(wp_len, cap);
      end
      if (flags[7]) add_string(un_len, cap);
      if (flags[6]) add_string(pw_len, cap);
   endtask

   // Queues the first count bytes of the body; last_at of -1 sets no last mark.
   task automatic send_body(input int count, input bit mark_first, input int last_at);
      int i;
      for (i = 0; i < count; i++)
         push_item(body_bytes[i], mark_first && i == 0, i == last_at);
   endtask

   // Mostly short strings, some empty, a few longer ones.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 0;
      if (r < 9) return $urandom_range(1, 6);
      return $urandom_range(7, 40);
   endfunction

   // Sender: bursts of random length separated by random gaps. A new request
   // is only put up once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) accepted_count++;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (next_idx < stim_q.size()) begin
            req_tdata  <= stim_q[next_idx].data_byte;
            req_tlast  <= stim_q[next_idx].last_byte;
            req_tuser  <= stim_q[next_idx].first_byte;
            req_tvalid <= 1'b1;
            next_idx++;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 23);
               gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: a fresh ready pattern per window, either all ready,
   // random or mostly ready. Twice it holds off long enough for the parser's
   // queue to fill while the sender keeps offering requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == 300 || rx_cycle == 1000) hold_left = HoldOffCycles;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_cycle % 16 == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_mask = '1;
                  1:       ready_mask = 16'($urandom);
                  default: ready_mask = 16'($urandom | $urandom);
               endcase
            end
            rsp_tready <= ready_mask[rx_cycle % 16];
         end
      end
   end

   // Watchdog: ends the run when no request or response moves for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < StallLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("No handshake for %0d cycles, giving up.", StallLimit);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int         pick;
      int         k;
      int         n;
      int         i;
      int         cap;
      int         lens[6];
      logic [7:0] flags;

      // Directed: every flag set (will QoS 3, reserved bit too), keep-alive at its
      // maximum and all five strings after the protocol name empty, so the body
      // completes on a length prefix. Trailing bytes follow, with and without last.
      build_body(8'hFF, 16'hFFFF, 4, 0, 0, 0, 0, 0, 1000);
      send_body(body_bytes.size(), 1'b1, body_bytes.size() - 1);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'hFF, 1'b0, 1'b0);

      // Directed: all-zero flags and keep-alive, empty protocol name, then a last
      // mark on the flags byte. The bytes after it must be tagged as after error.
      build_body(8'h00, 16'h0000, 0, 3, 0, 0, 0, 0, 1000);
      send_body(4, 1'b1, 3);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);

      // Random bodies: mostly well-formed, the rest cut short, restarted,
      // declared with huge string lengths, or plain noise.
      while (stim_q.size() < TargetItems) begin
         pick  = $urandom_range(0, 99);
         flags = 8'($urandom_range(0, 255));
         for (i = 0; i < 6; i++) lens[i] = pick_len();
         cap = 1000;
         if (pick >= 80 && pick < 88) begin
            lens[$urandom_range(0, 5)] = $urandom_range(41, 65535);
            cap = $urandom_range(8, 60);
         end
         build_body(flags, 16'($urandom_range(0, 65535)), lens[0], lens[1], lens[2],
                    lens[3], lens[4], lens[5], cap);
         if (pick < 55) begin
            send_body(body_bytes.size(), 1'b1, body_bytes.size() - 1);
         end else if (pick < 65) begin
            // Trailing bytes after a complete body, the last mark anywhere or nowhere.
            send_body(body_bytes.size(), 1'b1,
                      $urandom_range(0, 1) ? body_bytes.size() - 1 : -1);
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
               push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else if (pick < 80) begin
            // Truncated body, then a few bytes the parser must treat as after error.
            k = $urandom_range(0, body_bytes.size() - 2);
            send_body(k + 1, 1'b1, k);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
               push_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else if (pick < 88) begin
            send_body(body_bytes.size(), 1'b1, body_bytes.size() - 1);
         end else if (pick < 95) begin
            // Abandoned mid-body; the next first mark restarts the parser.
            k = $urandom_range(0, body_bytes.size() - 2);
            send_body(k + 1, 1'b1, -1);
         end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Counters are read at the falling edge, well after the rising-edge updates.
      while (accepted_count < stim_q.size() || pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);

      $display("Sent %0d body bytes: %0d bodies parsed to completion, %0d cut short by an",
               stim_q.size(), bodies_complete, bodies_truncated);
      $display("early last, %0d trailing bytes; receiver held off twice for %0d cycles.",
               trailing_bytes, HoldOffCycles);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/mcbp_pkg.sv
design/mcbp_queue.sv
design/mcbp_engine.sv
design/mqtt_connect_body_parser.sv
design/mcbp_checker.sv
verif/mcbp_result_checker.sv
verif/tb.sv
